[rtl/core/llpm_pkg.sv]
// Shared types and constants for the level line pixel map.
package llpm_pkg;

   localparam int PIX_W  = 8;
   localparam int STEP_W = 8;
   localparam int OFF_W  = 9;
   localparam int DIFF_W = 11;
   localparam int QUOT_W = 9;
   localparam int IW_W   = 11;
   localparam int MODE_W = 2;
   localparam int IDX_W  = 3;
   localparam int CSR_W  = 11;

   localparam logic [MODE_W-1:0] MODE_LEVEL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BILEVEL = 2'd2;

   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [IDX_W-1:0] REG_DISPLAY_MODE  = 3'd1;
   localparam logic [IDX_W-1:0] REG_BACKGROUND_ON = 3'd2;
   localparam logic [IDX_W-1:0] REG_GRID_STEP     = 3'd3;
   localparam logic [IDX_W-1:0] REG_GRID_OFFSET   = 3'd4;

   localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;
   localparam logic [PIX_W-1:0] DIM_BASE  = 8'd64;

   typedef struct packed {
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] prev;
      logic             first_row;
   } ctx_type;

endpackage

[rtl/core/llpm_if.sv]
// Request and response channel interfaces for the level line pixel map.
interface llpm_req_if;
   logic                        valid;
   logic                        ready;
   logic [llpm_pkg::PIX_W-1:0]  pixel;
   logic                        frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface llpm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [llpm_pkg::PIX_W-1:0]  out_pixel;

   modport source (output valid, output out_pixel, input ready);
   modport sink (input valid, input out_pixel, output ready);
endinterface

[rtl/core/llpm_div.sv]
// Bit-serial restoring divider: |diff|/divisor, a quotient bit per step_en cycle.
module llpm_div (
   input  logic                               clock,
   input  logic                               load,
   input  logic                               step_en,
   input  logic signed [llpm_pkg::DIFF_W-1:0] diff,
   input  logic [llpm_pkg::STEP_W-1:0]        divisor,
   output logic [llpm_pkg::QUOT_W-1:0]        quot,
   output logic                               neg
);

   logic [llpm_pkg::DIFF_W-1:0] mag;
   logic [llpm_pkg::QUOT_W-1:0] num_ff;
   logic [llpm_pkg::QUOT_W-1:0] quot_ff;
   logic [llpm_pkg::STEP_W-1:0] rem_ff;
   logic                        neg_ff;
   logic [llpm_pkg::STEP_W:0]   trial;
   logic [llpm_pkg::STEP_W:0]   diff_rem;
   logic                        ge;

   assign mag      = diff[llpm_pkg::DIFF_W-1] ? llpm_pkg::DIFF_W'(-diff)
                                              : llpm_pkg::DIFF_W'(diff);
   assign trial    = {rem_ff, num_ff[llpm_pkg::QUOT_W-1]};
   assign ge       = trial >= {1'b0, divisor};
   assign diff_rem = trial - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff  <= mag[llpm_pkg::QUOT_W-1:0];
         quot_ff <= '0;
         rem_ff  <= '0;
         neg_ff  <= diff[llpm_pkg::DIFF_W-1];
      end else if (step_en) begin
         num_ff  <= {num_ff[llpm_pkg::QUOT_W-2:0], 1'b0};
         quot_ff <= {quot_ff[llpm_pkg::QUOT_W-2:0], ge};
         rem_ff  <= ge ? diff_rem[llpm_pkg::STEP_W-1:0] : trial[llpm_pkg::STEP_W-1:0];
      end
   end

   assign quot = quot_ff;
   assign neg  = neg_ff;

endmodule

[rtl/core/llpm_line_buf.sv]
// Row memory with column counter, previous pixel and first-row tracking.
module llpm_line_buf #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [llpm_pkg::PIX_W-1:0]        pixel,
   input  logic                              frame_start,
   input  logic [$clog2(MAX_WIDTH):0]        width,
   output llpm_pkg::ctx_type                 ctx
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [llpm_pkg::PIX_W-1:0] row_mem [MAX_WIDTH];
   logic [llpm_pkg::PIX_W-1:0] above_ff;
   logic [llpm_pkg::PIX_W-1:0] prev_ff;
   logic [llpm_pkg::PIX_W-1:0] prev_q_ff;
   logic                       first_q_ff;
   logic [CW-1:0]              col_ff;
   logic                       first_ff;
   logic [CW-1:0]              col;
   logic                       first_cur;
   logic [CW:0]                col_plus;
   logic                       wrap;
   logic [CW-1:0]              col_in;
   logic                       first_in;

   assign col       = frame_start ? '0 : col_ff;
   assign first_cur = frame_start | first_ff;
   assign col_plus  = {1'b0, col} + {{CW{1'b0}}, 1'b1};
   assign wrap      = col_plus >= width;
   assign col_in    = wrap ? '0 : col_plus[CW-1:0];
   assign first_in  = wrap ? 1'b0 : first_cur;

   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff     <= row_mem[col];
         row_mem[col] <= pixel;
         prev_q_ff    <= prev_ff;
         first_q_ff   <= first_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         col_ff   <= '0;
         first_ff <= 1'b1;
      end else if (accept) begin
         prev_ff  <= pixel;
         col_ff   <= col_in;
         first_ff <= first_in;
      end
   end

   assign ctx.above     = above_ff;
   assign ctx.prev      = prev_q_ff;
   assign ctx.first_row = first_q_ff;

endmodule

[rtl/core/level_line_pixel_map.sv]
// Top level of the level line pixel map.
// From an accepted request to the response valid: the row memory read as the request is
// accepted, the divider load in S_READ, nine bit-serial divider steps in S_DIV (9 quotient
// bits), then the response load in S_DONE. A new request is accepted only in the idle state,
// after the response is loaded; the done state waits while the response register is held.
// Synchronous active-high reset clears control state and loads register
// defaults; row memory contents are undefined until written.
module level_line_pixel_map #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   llpm_req_if.sink                          req_chan,
   llpm_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [llpm_pkg::IDX_W-1:0]        csr_index,
   input  logic [llpm_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = (CW + 1 > llpm_pkg::IW_W + 1) ? CW + 1 : llpm_pkg::IW_W + 1;
   localparam int CNT_W  = $clog2(llpm_pkg::QUOT_W);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [llpm_pkg::IW_W-1:0]       image_width_ff;
   logic [llpm_pkg::MODE_W-1:0]     mode_ff;
   logic                            bg_on_ff;
   logic [llpm_pkg::STEP_W-1:0]     grid_step_ff;
   logic [llpm_pkg::OFF_W-1:0]      grid_offset_ff;
   logic [llpm_pkg::PIX_W-1:0]      pix_ff;
   logic                            rsp_valid_ff;
   logic [llpm_pkg::PIX_W-1:0]      rsp_pixel_ff;

   logic                            accept;
   logic                            rsp_load;
   logic [WW-1:0]                   width_ext;
   logic [WW-1:0]                   width_clamp;
   logic [llpm_pkg::STEP_W-1:0]     step_eff;
   llpm_pkg::ctx_type               ctx;
   logic                            div_load;
   logic                            div_step;
   logic signed [llpm_pkg::DIFF_W-1:0] d_v, d_p, d_a;
   logic [llpm_pkg::QUOT_W-1:0]     q_v, q_p, q_a;
   logic                            n_v, n_p, n_a;
   logic [llpm_pkg::DIFF_W-1:0]     lv_v, lv_p, lv_a;
   logic [llpm_pkg::PIX_W-1:0]      shown;
   logic [llpm_pkg::PIX_W-1:0]      result;

   function automatic logic signed [llpm_pkg::DIFF_W-1:0] diff_of(
      input logic [llpm_pkg::PIX_W-1:0] v,
      input logic [llpm_pkg::OFF_W-1:0] off
   );
      return signed'({3'b000, v}) - signed'({2'b00, off});
   endfunction

   // level = (d + step) / step, truncated, from q = |d| / step
   function automatic logic [llpm_pkg::DIFF_W-1:0] level_of(
      input logic                        neg,
      input logic [llpm_pkg::QUOT_W-1:0] q
   );
      logic [llpm_pkg::DIFF_W-1:0] qx;
      qx = {2'b00, q};
      if (!neg) begin
         return qx + llpm_pkg::DIFF_W'(1);
      end
      if (q == '0) begin
         return '0;
      end
      return llpm_pkg::DIFF_W'(1) - qx;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= llpm_pkg::IW_W'(256);
         mode_ff        <= llpm_pkg::MODE_LEVEL;
         bg_on_ff       <= 1'b1;
         grid_step_ff   <= llpm_pkg::STEP_W'(20);
         grid_offset_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            llpm_pkg::REG_IMAGE_WIDTH:   image_width_ff <= csr_wdata;
            llpm_pkg::REG_DISPLAY_MODE:  mode_ff        <= csr_wdata[llpm_pkg::MODE_W-1:0];
            llpm_pkg::REG_BACKGROUND_ON: bg_on_ff       <= csr_wdata[0];
            llpm_pkg::REG_GRID_STEP:     grid_step_ff   <= csr_wdata[llpm_pkg::STEP_W-1:0];
            llpm_pkg::REG_GRID_OFFSET:   grid_offset_ff <= csr_wdata[llpm_pkg::OFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign width_ext = WW'(image_width_ff);

   always_comb begin
      if (width_ext == '0) begin
         width_clamp = WW'(1);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         width_clamp = WW'(MAX_WIDTH);
      end else begin
         width_clamp = width_ext;
      end
   end

   assign step_eff = (grid_step_ff == '0) ? llpm_pkg::STEP_W'(1) : grid_step_ff;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;

   llpm_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel       (req_chan.pixel),
      .frame_start (req_chan.frame_start),
      .width       (width_clamp[CW:0]),
      .ctx         (ctx)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= req_chan.pixel;
      end
   end

   assign div_load = (state_ff == S_READ);
   assign div_step = (state_ff == S_DIV);
   assign d_v      = diff_of(pix_ff, grid_offset_ff);
   assign d_p      = diff_of(ctx.prev, grid_offset_ff);
   assign d_a      = diff_of(ctx.above, grid_offset_ff);

   llpm_div u_div_cur (
      .clock (clock), .load (div_load), .step_en (div_step),
      .diff (d_v), .divisor (step_eff), .quot (q_v), .neg (n_v)
   );

   llpm_div u_div_prev (
      .clock (clock), .load (div_load), .step_en (div_step),
      .diff (d_p), .divisor (step_eff), .quot (q_p), .neg (n_p)
   );

   llpm_div u_div_above (
      .clock (clock), .load (div_load), .step_en (div_step),
      .diff (d_a), .divisor (step_eff), .quot (q_a), .neg (n_a)
   );

   assign lv_v = level_of(n_v, q_v);
   assign lv_p = level_of(n_p, q_p);
   assign lv_a = level_of(n_a, q_a);

   always_comb begin
      logic [llpm_pkg::PIX_W+1:0] t3;
      t3    = {2'b00, pix_ff} + {1'b0, pix_ff, 1'b0};
      shown = bg_on_ff ? (llpm_pkg::DIM_BASE + t3[llpm_pkg::PIX_W+1:2]) : llpm_pkg::PIX_WHITE;
   end

   always_comb begin
      case (mode_ff)
         llpm_pkg::MODE_LEVEL: begin
            if (ctx.first_row) begin
               result = llpm_pkg::PIX_WHITE;
            end else if ((lv_v != lv_p) || (lv_v != lv_a)) begin
               result = llpm_pkg::PIX_BLACK;
            end else begin
               result = shown;
            end
         end
         llpm_pkg::MODE_BILEVEL: begin
            result = q_v[0] ? shown : llpm_pkg::PIX_BLACK;
         end
         default: begin
            result = llpm_pkg::PIX_WHITE;
         end
      endcase
   end

   assign rsp_load = (state_ff == S_DONE) & (~rsp_valid_ff | rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(llpm_pkg::QUOT_W - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_pixel = rsp_pixel_ff;

   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ))
      else $error("accepted transaction did not start a memory read");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done state");

   a_first_row_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (mode_ff == llpm_pkg::MODE_LEVEL) && ctx.first_row)
      |=> (rsp_pixel_ff == llpm_pkg::PIX_WHITE))
      else $error("first-row pixel in level mode not white");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= CNT_W'(llpm_pkg::QUOT_W - 1)))
      else $error("divider step count overran");

endmodule

[tb/llpm_display_checker.sv]
// Checker for the level line pixel map: predicts each display pixel and compares responses.
module llpm_display_checker
   import llpm_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   llpm_req_if               req_mon,
   llpm_rsp_if               rsp_mon,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   output int unsigned       error_count,
   output int unsigned       pending
);

   logic [IW_W-1:0]   width_reg;
   logic [MODE_W-1:0] mode_reg;
   logic              bg_reg;
   logic [STEP_W-1:0] step_reg;
   logic [OFF_W-1:0]  off_reg;

   logic [PIX_W-1:0]  line_mem [MAX_WIDTH];
   logic [PIX_W-1:0]  last_pix;
   int unsigned       col;
   logic              top_row;
   logic [PIX_W-1:0]  expected_pixels [$];
   int unsigned       fails;

   function automatic int grid_level(logic [PIX_W-1:0] v, int stp);
      return (int'(v) - int'(off_reg) + stp) / stp;
   endfunction

   function automatic logic [PIX_W-1:0] shade(logic [PIX_W-1:0] v);
      return bg_reg ? PIX_W'(int'(DIM_BASE) + (int'(v) * 3) / 4) : PIX_WHITE;
   endfunction

   always @(posedge clock) begin : track
      int               eff_w;
      int               stp;
      int               lv;
      int               band;
      logic [PIX_W-1:0] want;
      logic [PIX_W-1:0] got;
      if (reset) begin
         width_reg = 11'd256;
         mode_reg  = MODE_LEVEL;
         bg_reg    = 1'b1;
         step_reg  = 8'd20;
         off_reg   = '0;
         last_pix  = '0;
         col       = 0;
         top_row   = 1'b1;
         fails     = 0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IMAGE_WIDTH:   width_reg = csr_wdata[IW_W-1:0];
               REG_DISPLAY_MODE:  mode_reg  = csr_wdata[MODE_W-1:0];
               REG_BACKGROUND_ON: bg_reg    = csr_wdata[0];
               REG_GRID_STEP:     step_reg  = csr_wdata[STEP_W-1:0];
               REG_GRID_OFFSET:   off_reg   = csr_wdata[OFF_W-1:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            eff_w = (width_reg == 0) ? 1 :
                    (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            stp = (step_reg == 0) ? 1 : int'(step_reg);
            if (req_mon.frame_start) begin
               col     = 0;
               top_row = 1'b1;
            end
            want = PIX_WHITE;
            case (mode_reg)
               MODE_LEVEL: begin
                  if (!top_row) begin
                     lv = grid_level(req_mon.pixel, stp);
                     if (grid_level(last_pix, stp) != lv || grid_level(line_mem[col], stp) != lv)
                        want = PIX_BLACK;
                     else
                        want = shade(req_mon.pixel);
                  end
               end
               MODE_BILEVEL: begin
                  band = (int'(req_mon.pixel) - int'(off_reg)) / stp;
                  want = band[0] ? shade(req_mon.pixel) : PIX_BLACK;
               end
               default: ;
            endcase
            line_mem[col] = req_mon.pixel;
            last_pix      = req_mon.pixel;
            col++;
            if (col >= eff_w) begin
               col     = 0;
               top_row = 1'b0;
            end
            expected_pixels.push_back(want);
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.out_pixel;
            if (expected_pixels.size() == 0) begin
               $error("out_pixel: unexpected transaction, got %0d", got);
               fails++;
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  $error("out_pixel mismatch: expected %0d, got %0d", want, got);
                  fails++;
               end
            end
         end
      end
      pending     <= expected_pixels.size();
      error_count <= fails;
   end

endmodule

[tb/tb_level_line_pixel_map.sv]
// Testbench top for the level line pixel map: stimulus, flow control and verdict.
module tb_level_line_pixel_map
   import llpm_pkg::*;
;

   localparam int MAX_WIDTH   = 1024;
   localparam int TOTAL_ITEMS = 1850;
   localparam int DRAIN_WAIT  = 16;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int unsigned      error_count;
   int unsigned      pending;

   llpm_req_if req_bus ();
   llpm_rsp_if rsp_bus ();

   int unsigned      sent_count = 0;
   int               cur_width  = 256;
   logic             frame_due  = 1'b0;
   logic [PIX_W-1:0] drift_pix  = '0;

   level_line_pixel_map #(
      .MAX_WIDTH (MAX_WIDTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   llpm_display_checker #(
      .MAX_WIDTH (MAX_WIDTH)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending)
   );

   always #4 clock = ~clock;

   // Mostly a slow drift so that neighbouring levels often agree.
   function automatic logic [PIX_W-1:0] next_pixel();
      int r;
      int v;
      r = $urandom_range(0, 15);
      case (r)
         0: v = 0;
         1: v = 255;
         2, 3, 4: v = $urandom_range(0, 255);
         5, 6: v = int'(drift_pix);
         default: v = int'(drift_pix) + int'($urandom_range(0, 6)) - 3;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      drift_pix = PIX_W'(v);
      return PIX_W'(v);
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      int gap;
      gap = ((sent_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pixel       <= pix;
      req_bus.frame_start <= fs | frame_due;
      frame_due = 1'b0;
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
   endtask

   task automatic run_image(input int count, input int fs_percent);
      logic fs;
      for (int k = 0; k < count; k++) begin
         fs = ($urandom_range(0, 99) < fs_percent);
         send_pixel(next_pixel(), fs);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input int value, input int fw);
      logic [CSR_W-1:0] junk;
      junk = CSR_W'($urandom());
      junk = junk << fw;
      csr_we    <= 1'b1;
      csr_index <= idx;
      if ($urandom_range(0, 1))
         csr_wdata <= junk | CSR_W'(value);
      else
         csr_wdata <= CSR_W'(value);
      @(posedge clock);
   endtask

   task automatic configure(input int w, input int m, input int b, input int s, input int o,
                            input int strays);
      int eff;
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, w, IW_W);
      write_reg(REG_DISPLAY_MODE, m, MODE_W);
      write_reg(REG_BACKGROUND_ON, b, 1);
      write_reg(REG_GRID_STEP, s, STEP_W);
      write_reg(REG_GRID_OFFSET, o, OFF_W);
      for (int k = 0; k < strays; k++)
         write_reg(IDX_W'(REG_GRID_OFFSET + 1 + (k % 3)), $urandom_range(0, 2047), CSR_W);
      csr_we <= 1'b0;
      // a wider row would read line entries never written: restart the image
      eff = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      if (eff > cur_width) frame_due = 1'b1;
      cur_width = eff;
   endtask

   task automatic random_settings();
      int r;
      int w;
      int m;
      int s;
      int o;
      r = $urandom_range(0, 19);
      case (r)
         0: w = 0;
         1: w = 1;
         2: w = $urandom_range(MAX_WIDTH + 1, 2047);
         3, 4: w = $urandom_range(25, 300);
         default: w = $urandom_range(2, 24);
      endcase
      r = $urandom_range(0, 9);
      case (r)
         0: m = 0;
         1: m = 3;
         2, 3, 4, 5: m = MODE_LEVEL;
         default: m = MODE_BILEVEL;
      endcase
      r = $urandom_range(0, 9);
      case (r)
         0: s = 0;
         1: s = 1;
         2: s = 255;
         3, 4: s = $urandom_range(1, 255);
         default: s = $urandom_range(2, 40);
      endcase
      r = $urandom_range(0, 9);
      case (r)
         0: o = 0;
         1: o = 509;
         2, 3: o = $urandom_range(0, 509);
         default: o = $urandom_range(0, 200);
      endcase
      configure(w, m, $urandom_range(0, 1), s, o, $urandom_range(0, 1));
   endtask

   initial begin : stimulus
      logic big_done;
      logic wide_done;
      big_done  = 1'b0;
      wide_done = 1'b0;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.pixel       <= '0;
      req_bus.frame_start <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-pixel rows
      configure(1, MODE_LEVEL, 1, 1, 0, 0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);

      // widest step, offset of 509, white background
      configure(4, MODE_LEVEL, 0, 255, 509, 0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd10, 1'b0);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd128, 1'b0);

      // width shrinks while the column sits past it
      configure(2, MODE_LEVEL, 1, 1, 0, 0);
      send_pixel(8'd37, 1'b0);
      send_pixel(8'd36, 1'b0);
      send_pixel(8'd200, 1'b0);

      // zero width and zero step, bi-level with negative bands
      configure(0, MODE_BILEVEL, 1, 0, 509, 0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd1, 1'b1);
      send_pixel(8'd254, 1'b0);

      // unused modes, with writes to unmapped indexes
      configure(0, 0, 1, 20, 0, 3);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      configure(0, 3, 1, 20, 0, 0);
      send_pixel(8'd128, 1'b1);
      send_pixel(8'd7, 1'b0);

      while (sent_count < TOTAL_ITEMS) begin
         if (!big_done && sent_count >= 400) begin
            // a full maximum-width row and a little of the next
            configure(2047, MODE_LEVEL, $urandom_range(0, 1), $urandom_range(4, 40),
                      $urandom_range(0, 60), 0);
            run_image(MAX_WIDTH + 16, 0);
            big_done = 1'b1;
         end else if (!wide_done && sent_count >= 1500) begin
            configure(MAX_WIDTH, MODE_BILEVEL, 1, $urandom_range(1, 255),
                      $urandom_range(0, 509), 0);
            run_image(60, 0);
            wide_done = 1'b1;
         end else begin
            random_settings();
            run_image($urandom_range(20, 60), 3);
         end
      end

      wait_idle();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin : receiver
      int          gap;
      int unsigned taken;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (taken == 250 || taken == 1200) begin
            // long hold-off: the block backs up and stalls its input
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            gap = ((taken / 64) % 3 == 1) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
      end
   end

   initial begin : watchdog
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule
